// File: sv/rpn_stack_evaluator_top_assert.svh
// Assertion helpers for the RPN evaluator.
// The using module provides clk_i and rst_ni.
`ifndef RPN_STACK_EVALUATOR_TOP_ASSERT_SVH
`define RPN_STACK_EVALUATOR_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define RPN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked at every clock edge outside reset.
`define RPN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

// File: sv/rpn_pkg.sv
`default_nettype none

package rpn_pkg;

  localparam int unsigned STACK_DEPTH   = 128;
  localparam int unsigned FRACTION_BITS = 16;

  // Quotient bits produced by the divider after the saturation pre-check.
  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_FINISH = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FEW      = 3'd1,
    ST_DIV_ZERO = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_BAD_DEPTH = 3'd4,
    ST_SKIPPED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    STK_NONE   = 2'd0,
    STK_PUSH   = 2'd1,
    STK_POP_WR = 2'd2,
    STK_CLEAR  = 2'd3
  } stk_act_e;

  typedef enum logic [1:0] {
    TOP_ZERO = 2'd0,
    TOP_TOS  = 2'd1,
    TOP_VAL  = 2'd2,
    TOP_RES  = 2'd3
  } top_sel_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] top_value;
    logic               expression_done;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     rd_a;
    logic     mul_go;
    logic     div_go;
    stk_act_e stk;
    logic     err_set;
    logic     err_clr;
    logic     out_load;
    status_e  status;
    top_sel_e top_sel;
    logic     done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       depth_zero;
    logic       depth_one;
    logic       depth_full;
    logic       depth_lt2;
    logic       err;
    status_e    err_code;
    logic       b_zero;
    logic       div_busy;
    logic       out_free;
  } stat_t;

  // Clamp a 33-bit signed sum to 32 bits.
  function automatic logic [31:0] sat_sum(input logic [32:0] s);
    logic [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // Apply sign to a magnitude and saturate; hi flags bits above 31.
  function automatic logic [31:0] sat_mag(input logic neg, input logic hi,
                                          input logic [31:0] lo);
    logic [31:0] r;
    if (hi || lo[31]) begin
      r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = neg ? (32'd0 - lo) : lo;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/rpn_div.sv
`default_nettype none

module rpn_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output logic             sat_o,
  output logic [32:0]      quo_o
);

  logic [rpn_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [31:0] rem_q;
  logic [32:0] low_q;
  logic [31:0] b_q;
  logic [32:0] q_q;
  logic        sat_q;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // Trial subtract of one restoring step
  assign trial = {rem_q, low_q[32]};
  assign diff  = trial - {1'b0, b_q};
  assign ge    = (trial >= {1'b0, b_q});

  // Count the remaining steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - rpn_pkg::DIV_CNT_W'(1);
    end
  end

  // Load operands, then shift in one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i[63:33]};
      low_q <= dividend_i[32:0];
      b_q   <= divisor_i;
      q_q   <= '0;
      sat_q <= ({1'b0, dividend_i[63:33]} >= divisor_i);
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      low_q <= {low_q[31:0], 1'b0};
      q_q   <= {q_q[31:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign sat_o  = sat_q;
  assign quo_o  = q_q;

endmodule

`default_nettype wire

// File: sv/rpn_dp.sv
`default_nettype none

`include "rpn_stack_evaluator_top_assert.svh"

module rpn_dp #(
  parameter int unsigned STACK_DEPTH   = rpn_pkg::STACK_DEPTH,
  parameter int unsigned FRACTION_BITS = rpn_pkg::FRACTION_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rpn_pkg::in_word_t in_word_i,
  input  wire rpn_pkg::cmd_t     cmd_i,
  output rpn_pkg::stat_t         stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rpn_pkg::out_word_t     out_word_o
);

  localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  logic [31:0] mem [STACK_DEPTH];

  logic [2:0]             op_q;
  logic [31:0]            val_q;
  logic [31:0]            top_q;
  logic [31:0]            rd_q;
  logic [63:0]            prod_q;
  logic [DW-1:0]          depth_q;
  logic                   err_q;
  rpn_pkg::status_e       err_code_q;
  logic                   out_valid_q;
  rpn_pkg::out_word_t     out_q;

  logic [DW-1:0] depth_m2;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          mem_we;
  logic          neg;
  logic [31:0]   a_mag;
  logic [31:0]   b_mag;
  logic [32:0]   sum;
  logic [63:0]   prod_sh;
  logic [63:0]   dvd;
  logic          div_busy;
  logic          div_sat;
  logic [32:0]   div_quo;
  logic [31:0]   res;
  logic [31:0]   out_top;
  logic          out_free;

  // Capture the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_word_i.op;
      val_q <= in_word_i.operand_value;
    end
  end

  // Operand a sits below the cached top b
  assign depth_m2 = depth_q - DW'(2);
  assign neg      = rd_q[31] ^ top_q[31];
  assign a_mag    = rd_q[31] ? (32'd0 - rd_q) : rd_q;
  assign b_mag    = top_q[31] ? (32'd0 - top_q) : top_q;
  assign dvd      = 64'(a_mag) << FRACTION_BITS;
  assign prod_sh  = prod_q >> FRACTION_BITS;

  always_comb begin
    if (op_q == rpn_pkg::OP_SUB) begin
      sum = {rd_q[31], rd_q} - {top_q[31], top_q};
    end else begin
      sum = {rd_q[31], rd_q} + {top_q[31], top_q};
    end
  end

  // Register the magnitude product
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      prod_q <= 64'(a_mag) * 64'(b_mag);
    end
  end

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (dvd),
    .divisor_i  (b_mag),
    .busy_o     (div_busy),
    .sat_o      (div_sat),
    .quo_o      (div_quo)
  );

  // Select the arithmetic result
  always_comb begin
    case (op_q)
      rpn_pkg::OP_ADD,
      rpn_pkg::OP_SUB: res = rpn_pkg::sat_sum(sum);
      rpn_pkg::OP_MUL: res = rpn_pkg::sat_mag(neg, |prod_sh[63:32], prod_sh[31:0]);
      rpn_pkg::OP_DIV: res = rpn_pkg::sat_mag(neg, div_sat | div_quo[32], div_quo[31:0]);
      default:         res = '0;
    endcase
  end

  // Stack memory: one write port, one registered read port
  assign mem_we  = (cmd_i.stk == rpn_pkg::STK_PUSH) || (cmd_i.stk == rpn_pkg::STK_POP_WR);
  assign wr_addr = (cmd_i.stk == rpn_pkg::STK_PUSH) ? depth_q[IW-1:0] : depth_m2[IW-1:0];
  assign wr_data = (cmd_i.stk == rpn_pkg::STK_PUSH) ? val_q : res;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_a) begin
      rd_q <= mem[depth_m2[IW-1:0]];
    end
  end

  // Track depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      case (cmd_i.stk)
        rpn_pkg::STK_PUSH:   depth_q <= depth_q + DW'(1);
        rpn_pkg::STK_POP_WR: depth_q <= depth_q - DW'(1);
        rpn_pkg::STK_CLEAR:  depth_q <= '0;
        default:             depth_q <= depth_q;
      endcase
    end
  end

  // Hold a copy of the top entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.stk == rpn_pkg::STK_PUSH) begin
      top_q <= val_q;
    end else if (cmd_i.stk == rpn_pkg::STK_POP_WR) begin
      top_q <= res;
    end
  end

  // Latch the first error until finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q      <= 1'b0;
      err_code_q <= rpn_pkg::ST_OK;
    end else if (cmd_i.err_clr) begin
      err_q      <= 1'b0;
      err_code_q <= rpn_pkg::ST_OK;
    end else if (cmd_i.err_set) begin
      err_q      <= 1'b1;
      err_code_q <= cmd_i.status;
    end
  end

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.top_sel)
      rpn_pkg::TOP_TOS: out_top = top_q;
      rpn_pkg::TOP_VAL: out_top = val_q;
      rpn_pkg::TOP_RES: out_top = res;
      default:          out_top = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status          <= cmd_i.status;
      out_q.top_value       <= out_top;
      out_q.expression_done <= cmd_i.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Report status
  always_comb begin
    stat_o            = '0;
    stat_o.op         = op_q;
    stat_o.depth_zero = (depth_q == '0);
    stat_o.depth_one  = (depth_q == DW'(1));
    stat_o.depth_full = (depth_q >= DW'(STACK_DEPTH));
    stat_o.depth_lt2  = (depth_q < DW'(2));
    stat_o.err        = err_q;
    stat_o.err_code   = err_code_q;
    stat_o.b_zero     = (top_q == '0);
    stat_o.div_busy   = div_busy;
    stat_o.out_free   = out_free;
  end

  `RPN_ASSERT_IMPL(a_no_overwrite, cmd_i.out_load, out_free, "result overwritten while stalled")
  `RPN_ASSERT_ALWAYS(a_depth_range, depth_q <= DW'(STACK_DEPTH), "stack depth out of range")
  `RPN_ASSERT_IMPL(a_push_room, cmd_i.stk == rpn_pkg::STK_PUSH, !stat_o.depth_full, "push when full")
  `RPN_ASSERT_IMPL(a_pop_two, cmd_i.stk == rpn_pkg::STK_POP_WR, !stat_o.depth_lt2, "pop below two")

endmodule

`default_nettype wire

// File: sv/rpn_ctrl.sv
`default_nettype none

module rpn_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire rpn_pkg::stat_t stat_i,
  output rpn_pkg::cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_OPND = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_WB   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Sequence one word at a time
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end

      S_DEC: begin
        if (stat_i.op == rpn_pkg::OP_FINISH) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.done     = 1'b1;
            cmd_o.stk      = rpn_pkg::STK_CLEAR;
            cmd_o.err_clr  = 1'b1;
            if (stat_i.err) begin
              cmd_o.status = stat_i.err_code;
            end else if (!stat_i.depth_one) begin
              cmd_o.status = rpn_pkg::ST_BAD_DEPTH;
            end else begin
              cmd_o.top_sel = rpn_pkg::TOP_TOS;
            end
            state_d = S_IDLE;
          end
        end else if (stat_i.err) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.status   = rpn_pkg::ST_SKIPPED;
            state_d        = S_IDLE;
          end
        end else begin
          case (stat_i.op)
            rpn_pkg::OP_PUSH: begin
              if (stat_i.out_free) begin
                cmd_o.out_load = 1'b1;
                if (stat_i.depth_full) begin
                  cmd_o.status  = rpn_pkg::ST_OVERFLOW;
                  cmd_o.err_set = 1'b1;
                end else begin
                  cmd_o.stk     = rpn_pkg::STK_PUSH;
                  cmd_o.top_sel = rpn_pkg::TOP_VAL;
                end
                state_d = S_IDLE;
              end
            end
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
              if (!stat_i.depth_lt2) begin
                cmd_o.rd_a = 1'b1;
                state_d    = S_OPND;
              end else if (stat_i.out_free) begin
                cmd_o.out_load = 1'b1;
                cmd_o.status   = rpn_pkg::ST_FEW;
                cmd_o.err_set  = 1'b1;
                state_d        = S_IDLE;
              end
            end
            default: begin
              // Unused codes: report the current top
              if (stat_i.out_free) begin
                cmd_o.out_load = 1'b1;
                cmd_o.top_sel  = stat_i.depth_zero ? rpn_pkg::TOP_ZERO : rpn_pkg::TOP_TOS;
                state_d        = S_IDLE;
              end
            end
          endcase
        end
      end

      S_OPND: begin
        case (stat_i.op)
          rpn_pkg::OP_MUL: begin
            cmd_o.mul_go = 1'b1;
            state_d      = S_MUL;
          end
          rpn_pkg::OP_DIV: begin
            if (!stat_i.b_zero) begin
              cmd_o.div_go = 1'b1;
              state_d      = S_DIV;
            end else if (stat_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.status   = rpn_pkg::ST_DIV_ZERO;
              cmd_o.err_set  = 1'b1;
              state_d        = S_IDLE;
            end
          end
          default: state_d = S_WB;
        endcase
      end

      S_MUL: state_d = S_WB;

      S_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = S_WB;
        end
      end

      S_WB: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.stk      = rpn_pkg::STK_POP_WR;
          cmd_o.top_sel  = rpn_pkg::TOP_RES;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/rpn_stack_evaluator_top.sv
// Channel | Direction | Handshake                | Word
// in      | input     | in_valid_i / in_stall_o   | rpn_pkg::in_word_t  (op, operand_value)
// out     | output    | out_valid_o / out_stall_i | rpn_pkg::out_word_t (status, top_value,
//         |           |                           |   expression_done)
// One word in at a time; push, finish, unused codes and decode-time errors end at decode.
// Operators read operand a via the registered stack port; divide by zero stops there,
// others write back after a product step for multiply or 33 restoring steps for divide.
// A finished word waits in the output register; the next input word is accepted meanwhile.
// A stalled output holds the controller at its final step until the register frees.
// Reset is asynchronous, active low; the stack needs no clearing pass.
`default_nettype none

module rpn_stack_evaluator_top #(
  parameter int unsigned STACK_DEPTH   = rpn_pkg::STACK_DEPTH,
  parameter int unsigned FRACTION_BITS = rpn_pkg::FRACTION_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rpn_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rpn_pkg::out_word_t     out_word_o
);

  rpn_pkg::cmd_t  cmd;
  rpn_pkg::stat_t stat;

  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rpn_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpn_pkg::*;

  // Unused op codes act as no-ops when no error is latched
  localparam logic [2:0] OP_NOP_6 = 3'd6;
  localparam logic [2:0] OP_NOP_7 = 3'd7;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  localparam int     RANDOM_WORDS = 900;
  localparam int     DEAD_LIMIT   = 2000;
  localparam int     DRAIN_CYCLES = 60;
  localparam longint Q_MAX        = 64'sd2147483647;
  localparam longint Q_MIN        = -64'sd2147483648;

  typedef struct {
    in_word_t  w;
    logic      typed;
    out_word_t answer;
  } vector_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_word_t out_word_o;

  // Shadow of the evaluator state
  logic signed [31:0] calc_stack [STACK_DEPTH];
  int                 calc_depth    = 0;
  logic               calc_err      = 1'b0;
  status_e            calc_err_code = ST_OK;

  out_word_t awaited_answers [$];
  vector_t   directed_vectors [$];
  in_word_t  batch [$];
  int        mismatch_count = 0;
  int        dead_cycles    = 0;
  int        random_sent    = 0;
  logic      steady         = 1'b0;

  rpn_stack_evaluator_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] clamp_sum(input longint s);
    if (s > Q_MAX) return 32'h7FFF_FFFF;
    if (s < Q_MIN) return 32'h8000_0000;
    return s[31:0];
  endfunction

  // Apply the sign to a magnitude and saturate to 32 bits
  function automatic logic [31:0] signed_sat(input logic neg, input logic [63:0] mag);
    if (neg) begin
      return (mag >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // Advance the shadow stack by one word and return the answer it yields
  function automatic out_word_t evaluate_word(input in_word_t w);
    out_word_t   r;
    status_e     st;
    longint      a;
    longint      b;
    logic        neg;
    logic [31:0] res;
    r   = '0;
    st  = ST_OK;
    res = '0;
    if (w.op == OP_FINISH) begin
      r.expression_done = 1'b1;
      if (calc_err) begin
        st = calc_err_code;
      end else if (calc_depth != 1) begin
        st = ST_BAD_DEPTH;
      end else begin
        r.top_value = calc_stack[0];
      end
      calc_depth    = 0;
      calc_err      = 1'b0;
      calc_err_code = ST_OK;
    end else if (calc_err) begin
      st = ST_SKIPPED;
    end else if (w.op == OP_PUSH) begin
      if (calc_depth >= STACK_DEPTH) begin
        st = ST_OVERFLOW;
      end else begin
        calc_stack[calc_depth] = w.operand_value;
        calc_depth++;
        r.top_value = w.operand_value;
      end
    end else if (w.op >= OP_ADD && w.op <= OP_DIV) begin
      if (calc_depth < 2) begin
        st = ST_FEW;
      end else begin
        a   = calc_stack[calc_depth - 2];
        b   = calc_stack[calc_depth - 1];
        neg = (a < 0) != (b < 0);
        case (w.op)
          OP_ADD: res = clamp_sum(a + b);
          OP_SUB: res = clamp_sum(a - b);
          OP_MUL: res = signed_sat(neg, (magnitude(a) * magnitude(b)) >> FRACTION_BITS);
          default: begin
            if (b == 0) st = ST_DIV_ZERO;
            else res = signed_sat(neg, (magnitude(a) << FRACTION_BITS) / magnitude(b));
          end
        endcase
        if (st == ST_OK) begin
          calc_depth--;
          calc_stack[calc_depth - 1] = res;
          r.top_value = res;
        end
      end
    end else begin
      r.top_value = (calc_depth == 0) ? 32'd0 : calc_stack[calc_depth - 1];
    end
    if (st != ST_OK && st != ST_SKIPPED && w.op != OP_FINISH) begin
      calc_err      = 1'b1;
      calc_err_code = st;
    end
    r.status = st;
    return r;
  endfunction

  function automatic in_word_t make_word(input logic [2:0] op, input logic [31:0] val);
    in_word_t w;
    w.op            = op;
    w.operand_value = val;
    return w;
  endfunction

  function automatic logic [2:0] pick_arith();
    case ($urandom_range(3))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  // Mostly small Q16.16 values so results stay meaningful, with extremes mixed in
  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(15))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = '0;
      3, 4, 5: v = $urandom;
      default: begin
        v = $urandom_range(32'h000F_FFFF);
        if ($urandom_range(1) == 1) v = 32'd0 - v;
      end
    endcase
    return v;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [31:0] val, input logic typed,
                         input status_e st, input logic [31:0] top, input logic done);
    vector_t row;
    row.w                      = make_word(op, val);
    row.typed                  = typed;
    row.answer.status          = st;
    row.answer.top_value       = top;
    row.answer.expression_done = done;
    directed_vectors.push_back(row);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offer one word, idling first at random, and log its answer once accepted
  task automatic send_word(input in_word_t w, input logic typed, input out_word_t typed_answer);
    out_word_t predicted;
    if (!steady && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!steady && $urandom_range(99) < 28);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    predicted = evaluate_word(w);
    awaited_answers.push_back(typed ? typed_answer : predicted);
  endtask

  task automatic send_batch();
    foreach (batch[i]) send_word(batch[i], PREDICTED, '0);
    random_sent += batch.size();
    batch.delete();
  endtask

  // Well-formed expression over n operands, closed by a finish
  task automatic build_expression(input int n);
    int depth;
    int left;
    depth = 0;
    left  = n;
    while (left > 0 || depth > 1) begin
      if (left > 0 && (depth < 2 || $urandom_range(1) == 1)) begin
        batch.push_back(make_word(OP_PUSH, rand_value()));
        depth++;
        left--;
      end else begin
        batch.push_back(make_word(pick_arith(), rand_value()));
        depth--;
      end
      if ($urandom_range(19) == 0) begin
        batch.push_back(make_word($urandom_range(1) ? OP_NOP_7 : OP_NOP_6, $urandom));
      end
    end
    batch.push_back(make_word(OP_FINISH, $urandom));
  endtask

  // Fill the stack to the brim, then overflow it or fold it back down
  task automatic build_fill(input logic overflow);
    repeat (STACK_DEPTH) batch.push_back(make_word(OP_PUSH, rand_value()));
    if (overflow) begin
      repeat ($urandom_range(1, 2)) batch.push_back(make_word(OP_PUSH, rand_value()));
      batch.push_back(make_word(pick_arith(), rand_value()));
    end else begin
      repeat (STACK_DEPTH - 1) batch.push_back(make_word(pick_arith(), rand_value()));
    end
    batch.push_back(make_word(OP_FINISH, $urandom));
  endtask

  // Consume answers and compare them against the oldest expectation
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d top=%h done=%b",
                                  out_word_o.status, out_word_o.top_value,
                                  out_word_o.expression_done));
      end else begin
        want = awaited_answers.pop_front();
        if (out_word_o.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_word_o.status, want.status));
        if (out_word_o.top_value !== want.top_value)
          report_mismatch($sformatf("top_value %h, want %h", out_word_o.top_value,
                                    want.top_value));
        if (out_word_o.expression_done !== want.expression_done)
          report_mismatch($sformatf("expression_done %b, want %b",
                                    out_word_o.expression_done, want.expression_done));
      end
    end
  end

  // Stall the output side at random, except during the steady stretch
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 28);
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= DEAD_LIMIT) begin
      $display("[rpn_stack_evaluator_top] ERROR");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  initial begin
    int kind;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed vectors: empty stack, saturation, error latching, no-op codes
    add_row(OP_FINISH, 32'h0000_0000, TYPED, ST_BAD_DEPTH, 32'h0, 1'b1);
    add_row(OP_ADD,    32'h0000_0000, TYPED, ST_FEW,       32'h0, 1'b0);
    add_row(OP_PUSH,   32'h0005_0000, TYPED, ST_SKIPPED,   32'h0, 1'b0);
    add_row(OP_FINISH, 32'h0000_0000, TYPED, ST_FEW,       32'h0, 1'b1);
    add_row(OP_PUSH,   32'h7FFF_FFFF, TYPED, ST_OK, 32'h7FFF_FFFF, 1'b0);
    add_row(OP_PUSH,   32'h7FFF_FFFF, TYPED, ST_OK, 32'h7FFF_FFFF, 1'b0);
    add_row(OP_ADD,    32'hFFFF_FFFF, TYPED, ST_OK, 32'h7FFF_FFFF, 1'b0);
    add_row(OP_PUSH,   32'h8000_0000, TYPED, ST_OK, 32'h8000_0000, 1'b0);
    add_row(OP_SUB,    32'h0000_0000, TYPED, ST_OK, 32'h7FFF_FFFF, 1'b0);
    add_row(OP_FINISH, 32'hFFFF_FFFF, TYPED, ST_OK, 32'h7FFF_FFFF, 1'b1);
    add_row(OP_PUSH,   32'h8000_0000, TYPED, ST_OK, 32'h8000_0000, 1'b0);
    add_row(OP_PUSH,   32'h0001_0000, TYPED, ST_OK, 32'h0001_0000, 1'b0);
    add_row(OP_SUB,    32'h0000_0000, TYPED, ST_OK, 32'h8000_0000, 1'b0);
    add_row(OP_PUSH,   32'h8000_0000, TYPED, ST_OK, 32'h8000_0000, 1'b0);
    add_row(OP_MUL,    32'h0000_0000, TYPED, ST_OK, 32'h7FFF_FFFF, 1'b0);
    add_row(OP_PUSH,   32'h0000_0000, TYPED, ST_OK, 32'h0,         1'b0);
    add_row(OP_DIV,    32'h0000_0000, TYPED, ST_DIV_ZERO, 32'h0, 1'b0);
    add_row(OP_MUL,    32'h0000_0000, TYPED, ST_SKIPPED,  32'h0, 1'b0);
    add_row(OP_FINISH, 32'h0000_0000, TYPED, ST_DIV_ZERO, 32'h0, 1'b1);
    add_row(OP_NOP_6,  32'h1234_5678, TYPED, ST_OK,       32'h0, 1'b0);
    add_row(OP_PUSH,   32'h0003_0000, PREDICTED, ST_OK, 32'h0, 1'b0);
    add_row(OP_PUSH,   32'hFFFE_0000, PREDICTED, ST_OK, 32'h0, 1'b0);
    add_row(OP_DIV,    32'h0000_0000, PREDICTED, ST_OK, 32'h0, 1'b0);
    add_row(OP_NOP_7,  32'hFFFF_FFFF, PREDICTED, ST_OK, 32'h0, 1'b0);
    add_row(OP_PUSH,   32'h0002_0000, PREDICTED, ST_OK, 32'h0, 1'b0);
    add_row(OP_MUL,    32'h0000_0000, PREDICTED, ST_OK, 32'h0, 1'b0);
    add_row(OP_PUSH,   32'h0001_0000, PREDICTED, ST_OK, 32'h0, 1'b0);
    add_row(OP_FINISH, 32'h0000_0000, TYPED, ST_BAD_DEPTH, 32'h0, 1'b1);
    foreach (directed_vectors[i]) begin
      send_word(directed_vectors[i].w, directed_vectors[i].typed,
                directed_vectors[i].answer);
    end

    // Random sequences: mostly well-formed, some broken, some noise
    build_fill(1'b1);
    send_batch();
    while (random_sent < RANDOM_WORDS) begin
      steady <= (random_sent >= 300 && random_sent < 480);
      kind = $urandom_range(99);
      if (kind < 60) begin
        build_expression($urandom_range(1, 8));
      end else if (kind < 70) begin
        build_expression($urandom_range(9, 40));
      end else if (kind < 85) begin
        build_expression($urandom_range(1, 8));
        case ($urandom_range(2))
          0: batch.delete($urandom_range(batch.size() - 1));
          1: batch.insert($urandom_range(batch.size() - 1),
                          make_word(pick_arith(), rand_value()));
          default: void'(batch.pop_back());
        endcase
      end else if (kind < 97) begin
        repeat ($urandom_range(1, 8)) begin
          batch.push_back(make_word(3'($urandom_range(7)), $urandom));
        end
      end else begin
        build_fill(1'($urandom_range(1)));
      end
      send_batch();
    end
    steady     <= 1'b0;
    in_valid_i <= 1'b0;

    // Drain the remaining answers, then hold for stray words
    while (awaited_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[rpn_stack_evaluator_top] OK");
    end else begin
      $display("[rpn_stack_evaluator_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+sv
sv/rpn_pkg.sv
sv/rpn_div.sv
sv/rpn_dp.sv
sv/rpn_ctrl.sv
sv/rpn_stack_evaluator_top.sv
test/tb_top.sv
